>>> hdl/pgct_pkg.sv
// ----------------------------------------------------------------------------
// pgct_pkg
// Shared widths, register indexes, view mode codes and helper functions of
// the plane grid cell tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package pgct_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int FRAC_BITS    = 16;

    localparam int CELL_W    = 8;
    localparam int CNT_W     = 9;
    localparam int MODE_W    = 3;
    localparam int CRD_W     = 32;
    localparam int UV_W      = 17;
    localparam int CFG_IDX_W = 3;
    localparam int NORM_W    = 3;

    localparam int SPAN_W = CRD_W + 1;
    localparam int STEP_W = CNT_W + 2;
    localparam int PROD_W = SPAN_W + STEP_W;
    localparam int DEN_W  = CNT_W + 1;
    localparam int REM_W  = DEN_W;
    localparam int DIV_W  = CRD_W + CNT_W + 1;
    localparam int UV_SH  = FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_A_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_A_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_B_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_B_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd7;

    localparam logic [MODE_W-1:0] MODE_TOP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BOTTOM = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BACK   = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [CNT_W-1:0]         nc;
        logic [CNT_W-1:0]         nr;
        logic signed [SPAN_W-1:0] da;
        logic signed [SPAN_W-1:0] db;
        logic [CRD_W-1:0]         off;
        logic [CRD_W-1:0]         pw;
        logic [CRD_W-1:0]         ph;
    } t_geom;

    typedef struct packed {
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
    } t_cell;

    typedef struct packed {
        logic last;
        logic nega;
        logic negb;
    } t_side;

    function automatic logic [CNT_W-1:0] seg_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        m = n;
        if (n == '0) m = CNT_W'(1);
        else if (n > CNT_W'(MAX_SEGMENTS)) m = CNT_W'(MAX_SEGMENTS);
        return m;
    endfunction

    // corner steps along a and b; set 0 top, 1 bottom, 2 the side views
    function automatic logic corner_da(input logic [1:0] set, input logic [1:0] idx);
        logic b;
        b = (set == 2'd1) ? ~idx[1] : idx[1];
        return b;
    endfunction

    function automatic logic corner_db(input logic [1:0] set, input logic [1:0] idx);
        logic b;
        b = idx[1] ^ idx[0];
        if (set == 2'd2) b = ~b;
        return b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pgct_if.sv
// ----------------------------------------------------------------------------
// pgct_if
// Valid/ready channels of the tessellator: cell in, vertex out, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgct_cell_if;
    logic                        valid;
    logic                        ready;
    logic [pgct_pkg::CELL_W-1:0] cell_column;
    logic [pgct_pkg::CELL_W-1:0] cell_row;
    modport source (output valid, cell_column, cell_row, input ready);
    modport sink (input valid, cell_column, cell_row, output ready);
endinterface

interface pgct_vtx_if;
    logic                               valid;
    logic                               ready;
    logic signed [pgct_pkg::CRD_W-1:0]  pos_x;
    logic signed [pgct_pkg::CRD_W-1:0]  pos_y;
    logic signed [pgct_pkg::CRD_W-1:0]  pos_z;
    logic [pgct_pkg::UV_W-1:0]          tex_u;
    logic [pgct_pkg::UV_W-1:0]          tex_v;
    logic [pgct_pkg::NORM_W-1:0]        normal_dir;
    logic                               last_corner;
    logic [pgct_pkg::CRD_W-1:0]         plane_width;
    logic [pgct_pkg::CRD_W-1:0]         plane_height;
    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, normal_dir,
                    last_corner, plane_width, plane_height, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, normal_dir,
                  last_corner, plane_width, plane_height, output ready);
endinterface

interface pgct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pgct_pkg::CFG_IDX_W-1:0] index;
    logic [pgct_pkg::CRD_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/pgct_front.sv
// ----------------------------------------------------------------------------
// pgct_front
// Config registers, derived geometry, and cell intake with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module pgct_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    pgct_cfg_if.sink          i_cfg,
    pgct_cell_if.sink         i_cell,
    input  wire               i_full,
    output logic              o_push,
    output pgct_pkg::t_cell   o_cell,
    output pgct_pkg::t_geom   o_geom
);
    import pgct_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_cols, r_rows;
    logic [CRD_W-1:0]  r_alo, r_ahi, r_blo, r_bhi, r_off;
    t_geom             r_geom;
    logic              r_fv;
    logic [CELL_W-1:0] r_col, r_row;
    logic [CNT_W-1:0]  nc, nr;
    logic signed [SPAN_W-1:0] da, db;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TOP;
            r_cols <= CNT_W'(1);
            r_rows <= CNT_W'(1);
            r_alo  <= '0;
            r_ahi  <= '0;
            r_blo  <= '0;
            r_bhi  <= '0;
            r_off  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_VIEW_MODE:    r_mode <= i_cfg.data[MODE_W-1:0];
                REG_COLUMNS:      r_cols <= i_cfg.data[CNT_W-1:0];
                REG_ROWS:         r_rows <= i_cfg.data[CNT_W-1:0];
                REG_SPAN_A_LOW:   r_alo  <= i_cfg.data;
                REG_SPAN_A_HIGH:  r_ahi  <= i_cfg.data;
                REG_SPAN_B_LOW:   r_blo  <= i_cfg.data;
                REG_SPAN_B_HIGH:  r_bhi  <= i_cfg.data;
                REG_PLANE_OFFSET: r_off  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign nc = seg_count(r_cols);
    assign nr = seg_count(r_rows);
    assign da = $signed({r_ahi[CRD_W-1], r_ahi}) - $signed({r_alo[CRD_W-1], r_alo});
    assign db = $signed({r_bhi[CRD_W-1], r_bhi}) - $signed({r_blo[CRD_W-1], r_blo});

    // geometry is registered from the config registers, in the cycle after a write; the queue hides that lag
    always_ff @(posedge i_clk) begin
        r_geom.mode <= (r_mode > MODE_BACK) ? MODE_TOP : r_mode;
        r_geom.nc   <= nc;
        r_geom.nr   <= nr;
        r_geom.da   <= da;
        r_geom.db   <= db;
        r_geom.off  <= r_off;
        r_geom.pw   <= da[SPAN_W-1] ? '0 : da[CRD_W-1:0];
        r_geom.ph   <= db[SPAN_W-1] ? '0 : db[CRD_W-1:0];
    end

    assign o_push      = r_fv && !i_full;
    assign i_cell.ready = !r_fv || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_cell.ready) begin
            r_fv <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cell.ready && i_cell.valid) begin
            r_col <= i_cell.cell_column;
            r_row <= i_cell.cell_row;
        end
    end

    // clamp a cell beyond the grid to the last one
    always_comb begin
        o_cell.col = ({1'b0, r_col} >= nc) ? CELL_W'(nc - CNT_W'(1)) : r_col;
        o_cell.row = ({1'b0, r_row} >= nr) ? CELL_W'(nr - CNT_W'(1)) : r_row;
    end

    assign o_geom = r_geom;

endmodule

`default_nettype wire

>>> hdl/pgct_fifo.sv
// ----------------------------------------------------------------------------
// pgct_fifo
// Two-entry queue of clamped cells between intake and vertex generation.
// ----------------------------------------------------------------------------
`default_nettype none

module pgct_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  pgct_pkg::t_cell  i_cell,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output pgct_pkg::t_cell  o_cell
);
    import pgct_pkg::*;

    t_cell      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cell  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

>>> hdl/pgct_div.sv
// ----------------------------------------------------------------------------
// pgct_div
// Pipelined restoring divider, one quotient bit per stage, stall by enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pgct_div (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire [pgct_pkg::DIV_W-1:0]      i_num,
    input  wire [pgct_pkg::DEN_W-1:0]      i_den,
    output logic [pgct_pkg::DIV_W-1:0]     o_quo
);
    import pgct_pkg::*;

    logic [REM_W-1:0] r_rem [DIV_W];
    logic [DIV_W-1:0] r_nq  [DIV_W];
    logic [DEN_W-1:0] r_den [DIV_W];

    genvar g;
    generate
        for (g = 0; g < DIV_W; g++) begin : g_stage
            logic [REM_W-1:0] rem_in;
            logic [DIV_W-1:0] nq_in;
            logic [DEN_W-1:0] den_in;
            logic [REM_W:0]   t;
            logic             ge;
            logic [REM_W-1:0] n_rem;
            logic [DIV_W-1:0] n_nq;

            if (g == 0) begin : g_head
                assign rem_in = '0;
                assign nq_in  = i_num;
                assign den_in = i_den;
            end else begin : g_body
                assign rem_in = r_rem[g-1];
                assign nq_in  = r_nq[g-1];
                assign den_in = r_den[g-1];
            end

            // shift in the next dividend bit, subtract where it fits
            always_comb begin
                t     = {rem_in, nq_in[DIV_W-1]};
                ge    = (t >= {1'b0, den_in});
                n_rem = ge ? REM_W'(t - {1'b0, den_in}) : t[REM_W-1:0];
                n_nq  = {nq_in[DIV_W-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_nq[g]  <= n_nq;
                    r_den[g] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_nq[DIV_W-1];

endmodule

`default_nettype wire

>>> hdl/pgct_back.sv
// ----------------------------------------------------------------------------
// pgct_back
// Corner sequencer and vertex pipeline: multiply, round-bias, four divider
// lanes, then saturate, axis placement and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgct_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  pgct_pkg::t_geom  i_geom,
    input  wire              i_empty,
    input  pgct_pkg::t_cell  i_cell,
    output logic             o_pop,
    pgct_vtx_if.source       o_vtx
);
    import pgct_pkg::*;

    logic adv, issue;
    logic [1:0] r_cnr;
    logic [1:0] set;
    logic [CNT_W-1:0] ka, kb, ku, nu, kv, nv;
    logic signed [STEP_W-1:0] ta, tb;

    logic                     r0_v, r0_last;
    logic signed [PROD_W-1:0] r0_pa, r0_pb;
    logic [DIV_W-1:0]         r0_nu, r0_nv;
    logic [DEN_W-1:0]         r0_du, r0_dv;

    logic             r1_v;
    t_side            r1_sd;
    logic [DIV_W-1:0] r1_na, r1_nb, r1_nu, r1_nv;
    logic [DEN_W-1:0] r1_du, r1_dv;
    logic [PROD_W-1:0] mag_a, mag_b;

    logic  r_sv [DIV_W];
    t_side r_sd [DIV_W];
    logic [DIV_W-1:0] q_a, q_b, q_u, q_v;
    logic [CRD_W-1:0] sa, sb;

    logic r_ov;
    logic signed [CRD_W-1:0] r_px, r_py, r_pz;
    logic [UV_W-1:0]   r_tu, r_tv;
    logic [NORM_W-1:0] r_nd;
    logic              r_last;

    assign adv   = !r_ov || o_vtx.ready;
    assign issue = !i_empty && adv;
    assign o_pop = issue && (r_cnr == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnr <= 2'd0;
        else if (issue) r_cnr <= r_cnr + 2'd1;
    end

    // corner indices and texture operand choice for this mode
    always_comb begin
        set = (i_geom.mode == MODE_TOP) ? 2'd0 : (i_geom.mode == MODE_BOTTOM) ? 2'd1 : 2'd2;
        ka  = {1'b0, i_cell.col} + CNT_W'(corner_da(set, r_cnr));
        kb  = {1'b0, i_cell.row} + CNT_W'(corner_db(set, r_cnr));
        ta  = $signed({1'b0, ka, 1'b0}) - $signed({2'b00, i_geom.nc});
        tb  = $signed({1'b0, kb, 1'b0}) - $signed({2'b00, i_geom.nr});
        case (i_geom.mode)
            MODE_LEFT, MODE_BACK: begin
                ku = i_geom.nr - kb; nu = i_geom.nr;
                kv = i_geom.nc - ka; nv = i_geom.nc;
            end
            MODE_RIGHT: begin
                ku = kb; nu = i_geom.nr;
                kv = ka; nv = i_geom.nc;
            end
            MODE_BOTTOM, MODE_FRONT: begin
                ku = ka; nu = i_geom.nc;
                kv = i_geom.nr - kb; nv = i_geom.nr;
            end
            default: begin
                ku = ka; nu = i_geom.nc;
                kv = kb; nv = i_geom.nr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (adv) begin
            r0_v <= issue;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_last <= (r_cnr == 2'd3);
            r0_pa   <= $signed(i_geom.da) * ta;
            r0_pb   <= $signed(i_geom.db) * tb;
            r0_nu   <= (DIV_W'(ku) << UV_SH) + DIV_W'(nu);
            r0_nv   <= (DIV_W'(kv) << UV_SH) + DIV_W'(nv);
            r0_du   <= {nu, 1'b0};
            r0_dv   <= {nv, 1'b0};
        end
    end

    assign mag_a = r0_pa[PROD_W-1] ? PROD_W'(-r0_pa) : PROD_W'(r0_pa);
    assign mag_b = r0_pb[PROD_W-1] ? PROD_W'(-r0_pb) : PROD_W'(r0_pb);

    // add n so the quotient by 2n rounds half away from zero
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_sd.last <= r0_last;
            r1_sd.nega <= r0_pa[PROD_W-1] ^ (i_geom.mode == MODE_RIGHT);
            r1_sd.negb <= r0_pb[PROD_W-1];
            r1_na      <= mag_a[DIV_W-1:0] + DIV_W'(i_geom.nc);
            r1_nb      <= mag_b[DIV_W-1:0] + DIV_W'(i_geom.nr);
            r1_nu      <= r0_nu;
            r1_nv      <= r0_nv;
            r1_du      <= r0_du;
            r1_dv      <= r0_dv;
        end
    end

    pgct_div u_div_a (.i_clk(i_clk), .i_en(adv), .i_num(r1_na),
                      .i_den({i_geom.nc, 1'b0}), .o_quo(q_a));
    pgct_div u_div_b (.i_clk(i_clk), .i_en(adv), .i_num(r1_nb),
                      .i_den({i_geom.nr, 1'b0}), .o_quo(q_b));
    pgct_div u_div_u (.i_clk(i_clk), .i_en(adv), .i_num(r1_nu),
                      .i_den(r1_du), .o_quo(q_u));
    pgct_div u_div_v (.i_clk(i_clk), .i_en(adv), .i_num(r1_nv),
                      .i_den(r1_dv), .o_quo(q_v));

    // sideband rides alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_W; i++) r_sv[i] <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= r1_v;
            for (int i = 1; i < DIV_W; i++) r_sv[i] <= r_sv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0] <= r1_sd;
            for (int i = 1; i < DIV_W; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    function automatic logic [CRD_W-1:0] sat_pos(input logic [DIV_W-1:0] q, input logic neg);
        logic [CRD_W-1:0] v;
        logic [DIV_W-1:0] nq;
        nq = -q;
        if (!neg) v = (q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[CRD_W-1:0];
        else      v = (q > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000 : nq[CRD_W-1:0];
        return v;
    endfunction

    assign sa = sat_pos(q_a, r_sd[DIV_W-1].nega);
    assign sb = sat_pos(q_b, r_sd[DIV_W-1].negb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_sv[DIV_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (i_geom.mode)
                MODE_LEFT, MODE_RIGHT: begin
                    r_px <= i_geom.off; r_py <= sa; r_pz <= sb;
                end
                MODE_FRONT: begin
                    r_px <= sa; r_py <= sb; r_pz <= i_geom.off;
                end
                MODE_BACK: begin
                    r_px <= sb; r_py <= sa; r_pz <= i_geom.off;
                end
                default: begin
                    r_px <= sa; r_py <= i_geom.off; r_pz <= sb;
                end
            endcase
            r_tu   <= q_u[UV_W-1:0];
            r_tv   <= q_v[UV_W-1:0];
            r_nd   <= i_geom.mode;
            r_last <= r_sd[DIV_W-1].last;
        end
    end

    assign o_vtx.valid        = r_ov;
    assign o_vtx.pos_x        = r_px;
    assign o_vtx.pos_y        = r_py;
    assign o_vtx.pos_z        = r_pz;
    assign o_vtx.tex_u        = r_tu;
    assign o_vtx.tex_v        = r_tv;
    assign o_vtx.normal_dir   = r_nd;
    assign o_vtx.last_corner  = r_last;
    assign o_vtx.plane_width  = i_geom.pw;
    assign o_vtx.plane_height = i_geom.ph;

endmodule

`default_nettype wire

>>> hdl/plane_grid_cell_tessellator_unit.sv
// ----------------------------------------------------------------------------
// plane_grid_cell_tessellator_unit
// Turns one grid cell of an axis-aligned plane into its four corner vertices.
//
//   channel  dir  beat contents
//   i_cfg    in   register index, 32-bit write data
//   i_cell   in   cell_column, cell_row
//   o_vtx    out  position, texture u/v, normal, last flag, plane extents
//
// Each cell yields four corners: the corner sequencer issues one vertex per
// cycle, while the queue holds a cell and o_vtx is not stalled, into four
// pipelined dividers (one quotient bit per stage).
// Reset (i_rst_n low, synchronous) loads the default registers and empties
// the pipeline. A stalled o_vtx holds the whole vertex pipeline; the cell
// queue keeps taking cells until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_grid_cell_tessellator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pgct_cfg_if.sink    i_cfg,
    pgct_cell_if.sink   i_cell,
    pgct_vtx_if.source  o_vtx
);
    import pgct_pkg::*;

    logic  push, full, pop, empty;
    t_cell fcell, qcell;
    t_geom geom;

    pgct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(i_cfg), .i_cell(i_cell),
        .i_full(full), .o_push(push), .o_cell(fcell), .o_geom(geom)
    );

    pgct_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cell(fcell),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_cell(qcell)
    );

    pgct_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_geom(geom), .i_empty(empty),
        .i_cell(qcell), .o_pop(pop), .o_vtx(o_vtx)
    );

endmodule

`default_nettype wire

>>> hdl/pgct_checker.sv
// ----------------------------------------------------------------------------
// pgct_checker
// Port-level checks on the vertex channel of the tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

module pgct_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_valid,
    input wire                           i_ready,
    input wire [pgct_pkg::CRD_W-1:0]     i_pos_x,
    input wire [pgct_pkg::UV_W-1:0]      i_tex_u,
    input wire [pgct_pkg::NORM_W-1:0]    i_normal
);
    import pgct_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("vertex valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_pos_x))
        else $error("stalled vertex changed");

    a_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_normal <= NORM_W'(MODE_BACK))
        else $error("normal code out of range");

    a_uv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_tex_u <= UV_W'(1 << FRAC_BITS))
        else $error("texture u above one");

endmodule

bind plane_grid_cell_tessellator_unit pgct_checker u_pgct_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(o_vtx.valid), .i_ready(o_vtx.ready),
    .i_pos_x(o_vtx.pos_x), .i_tex_u(o_vtx.tex_u), .i_normal(o_vtx.normal_dir)
);

`default_nettype wire
